// ----- rtl/core/bcr_pkg.sv -----
// Ball collision response: shared types and constants.
// Holds the transaction structs, opcodes and register indexes.
// No dependencies.
package bcr_pkg;

	// Opcodes carried by an input transaction
	localparam logic [1:0] OP_MOVE  = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_BOX   = 2'd2;
	localparam logic [1:0] OP_PLANE = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BALL_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_POS_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_VEL_Z = 3'd6;
	localparam int unsigned CFG_DATA_W = 32;

	// Radius after reset: 1.0 in Q16.16
	localparam logic [30:0] RADIUS_RESET = 31'd65536;

	typedef struct packed {
		logic [1:0]          opcode;
		logic signed [31:0]  point_x;
		logic signed [31:0]  point_y;
		logic signed [31:0]  point_z;
		logic [30:0]         box_width;
		logic [30:0]         box_height;
		logic [30:0]         box_depth;
		logic signed [31:0]  normal_x;
		logic signed [31:0]  normal_y;
		logic signed [31:0]  normal_z;
		logic [20:0]         time_step;
	} item_t;

	typedef struct packed {
		logic                hit;
		logic signed [31:0]  pos_x;
		logic signed [31:0]  pos_y;
		logic signed [31:0]  pos_z;
		logic signed [31:0]  vel_x;
		logic signed [31:0]  vel_y;
		logic signed [31:0]  vel_z;
	} result_t;

endpackage

// ----- rtl/core/ball_collision_response.sv -----
// Ball collision response: top level with sequencer and shared datapath.
// Depends on bcr_pkg.
//
// Usage:
//  One ball, position and velocity in signed Q16.16. Each input transaction
//  (item_valid/item_ready) carries an opcode: move, set position, box
//  collision or plane collision. Each one returns exactly one result
//  transaction (result_valid/result_ready) with the hit flag and new state.
//  The write port (cfg_we/cfg_index/cfg_data) sets the ball radius; the
//  start-state registers are taken and dropped, since reset always leaves
//  them, and so the ball, at zero.
//  A miss ends early (box far away, zero length, plane out of reach). All
//  work runs on one 34x33 multiplier, a radix-2 root unit that does the
//  32-step square root and a radix-2 divider that does the 32-step
//  divisions (3 divisions for a plane, 6 for a box); item_ready is low
//  until the result is registered. A result waits in the output register
//  while the next transaction is accepted; a stalled receiver holds back
//  only the following result.
//  Reset: position and velocity zero, radius 1.0, no result pending.
module ball_collision_response (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  bcr_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output bcr_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [bcr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bcr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bcr_pkg::*;

	// Sequencer states
	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_SET      = 5'd1;
	localparam logic [4:0] S_MV_MUL   = 5'd2;
	localparam logic [4:0] S_MV_ADD   = 5'd3;
	localparam logic [4:0] S_BX_D     = 5'd4;
	localparam logic [4:0] S_SOP_MUL  = 5'd5;
	localparam logic [4:0] S_SOP_ADD  = 5'd6;
	localparam logic [4:0] S_SQ_INIT  = 5'd7;
	localparam logic [4:0] S_SQRT     = 5'd8;
	localparam logic [4:0] S_LEN      = 5'd9;
	localparam logic [4:0] S_DIV_INIT = 5'd10;
	localparam logic [4:0] S_DIV_STEP = 5'd11;
	localparam logic [4:0] S_DIV_END  = 5'd12;
	localparam logic [4:0] S_OFF_MUL  = 5'd13;
	localparam logic [4:0] S_PS_CHK   = 5'd14;
	localparam logic [4:0] S_PK_MUL   = 5'd15;
	localparam logic [4:0] S_PK_ADD   = 5'd16;
	localparam logic [4:0] S_RF_DOT   = 5'd17;
	localparam logic [4:0] S_RF_MUL   = 5'd18;
	localparam logic [4:0] S_RF_ADD   = 5'd19;
	localparam logic [4:0] S_FIN      = 5'd20;

	// Operand selection for sums of products and divisions
	localparam logic [2:0] SEL_SQ  = 3'd0;
	localparam logic [2:0] SEL_PS  = 3'd1;
	localparam logic [2:0] SEL_DOT = 3'd2;
	localparam logic [2:0] SEL_N   = 3'd3;
	localparam logic [2:0] SEL_OFF = 3'd4;

	localparam logic [1:0] LAST_AXIS = 2'd2;
	localparam logic [4:0] LAST_STEP = 5'd31;

	function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
		logic signed [51:0] hi;
		logic signed [51:0] lo;
		hi = 52'sd2147483647;
		lo = -52'sd2147483648;
		if (x > hi)
			return 32'sh7fffffff;
		else if (x < lo)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	// Round to nearest on a shift right by 16, halves upward
	function automatic logic signed [49:0] rnd16(input logic signed [65:0] x);
		logic signed [65:0] t;
		t = x + 66'sd32768;
		return t[65:16];
	endfunction

	// Control and architectural state
	logic [4:0]          state_q;
	logic [1:0]          idx_q;
	logic [4:0]          cnt_q;
	logic [2:0]          sel_q;
	logic                hit_q;
	logic                out_valid_q;
	logic [30:0]         radius_q;
	logic signed [31:0]  pos_q [0:2];
	logic signed [31:0]  vel_q [0:2];

	// Latched transaction and working registers
	logic [1:0]          op_q;
	logic signed [31:0]  pt_q  [0:2];
	logic [30:0]         ext_q [0:2];
	logic [20:0]         dt_q;
	logic signed [32:0]  vec_q [0:2];
	logic signed [17:0]  n_q   [0:2];
	logic signed [32:0]  k_q;
	logic signed [33:0]  dot2_q;
	logic signed [65:0]  prod_q;
	logic signed [65:0]  acc_q;
	logic [63:0]         sqv_q;
	logic [63:0]         sqr_q;
	logic [63:0]         sqb_q;
	logic [31:0]         rem_q;
	logic [31:0]         quo_q;
	logic                neg_q;
	result_t             out_q;

	logic                accept;
	logic signed [33:0]  mul_a;
	logic signed [32:0]  mul_b;
	logic signed [66:0]  mul_p;
	logic signed [32:0]  ps_diff;
	logic signed [33:0]  r34;
	logic signed [33:0]  bx_diff [0:2];
	logic signed [33:0]  bx_half [0:2];
	logic signed [33:0]  bx_cl   [0:2];
	logic signed [33:0]  bx_d    [0:2];
	logic [2:0]          bx_far;
	logic [31:0]         len_w;
	logic                len_miss;
	logic [63:0]         sq_t;
	logic                sq_ge;
	logic signed [65:0]  dvd_n;
	logic signed [65:0]  dvd;
	logic [65:0]         dvd_mag;
	logic [32:0]         div_r2;
	logic                div_ge;
	logic [32:0]         div_sub;
	logic signed [32:0]  quo_s;
	logic signed [49:0]  s_w;
	logic signed [49:0]  r50;
	logic signed [49:0]  k_w;
	logic                plane_miss;
	logic signed [49:0]  dot_w;

	assign accept       = item_valid && item_ready;
	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Shared multiplier operands
	assign ps_diff = 33'(pos_q[idx_q]) - 33'(pt_q[idx_q]);
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MV_MUL: begin
				mul_a = 34'(vel_q[idx_q]);
				mul_b = {12'd0, dt_q};
			end
			S_SOP_MUL: begin
				case (sel_q)
					SEL_SQ: begin
						mul_a = 34'(vec_q[idx_q]);
						mul_b = vec_q[idx_q];
					end
					SEL_PS: begin
						mul_a = 34'(ps_diff);
						mul_b = 33'(n_q[idx_q]);
					end
					SEL_DOT: begin
						mul_a = 34'(vel_q[idx_q]);
						mul_b = 33'(n_q[idx_q]);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			S_OFF_MUL: begin
				mul_a = 34'(vec_q[idx_q]);
				mul_b = k_q;
			end
			S_PK_MUL: begin
				mul_a = 34'(k_q);
				mul_b = 33'(n_q[idx_q]);
			end
			S_RF_MUL: begin
				mul_a = dot2_q;
				mul_b = 33'(n_q[idx_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Box: offset from the ball centre to the closest box point, per axis
	assign r34 = $signed({3'd0, radius_q});
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bx_diff[i] = 34'(pos_q[i]) - 34'(pt_q[i]);
			bx_half[i] = $signed({4'd0, ext_q[i][30:1]});
			if (bx_diff[i] > bx_half[i])
				bx_cl[i] = bx_half[i];
			else if (bx_diff[i] < -bx_half[i])
				bx_cl[i] = -bx_half[i];
			else
				bx_cl[i] = bx_diff[i];
			bx_d[i]   = bx_cl[i] - bx_diff[i];
			bx_far[i] = (bx_d[i] >= r34) || (-bx_d[i] >= r34);
		end
	end

	// Square root step
	assign sq_t  = sqr_q + sqb_q;
	assign sq_ge = (sqv_q >= sq_t);
	assign len_w = sqr_q[31:0];
	assign len_miss = (len_w == 32'd0) ||
		((op_q == OP_BOX) && (len_w >= {1'b0, radius_q}));

	// Divider: sign-magnitude restoring division, quotient below 2^32
	assign dvd_n   = 66'(vec_q[idx_q]) <<< 16;
	assign dvd     = (sel_q == SEL_OFF) ? prod_q : dvd_n;
	assign dvd_mag = dvd[65] ? 66'(-dvd) : 66'(dvd);
	assign div_r2  = {rem_q, quo_q[31]};
	assign div_ge  = (div_r2 >= {1'b0, len_w});
	assign div_sub = div_r2 - {1'b0, len_w};
	assign quo_s   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	// Plane: signed distance and push-out
	assign s_w = rnd16(acc_q);
	assign r50 = $signed({19'd0, radius_q});
	assign plane_miss = (s_w == 50'sd0) || (s_w >= r50) || (-s_w >= r50);
	assign k_w = (s_w > 50'sd0) ? (r50 - s_w) : (-r50 - s_w);
	assign dot_w = rnd16(acc_q);

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			sel_q       <= SEL_SQ;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			radius_q    <= RADIUS_RESET;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			// Radius write; start-state registers are dropped
			if (cfg_we && (cfg_index == REG_BALL_RADIUS))
				radius_q <= cfg_data[30:0];

			// Raise the result when registered, drop it once taken
			if ((state_q == S_FIN) && (!out_valid_q || result_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && result_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q <= 1'b0;
						idx_q <= '0;
						sel_q <= SEL_SQ;
						unique case (item.opcode)
							OP_MOVE:  state_q <= S_MV_MUL;
							OP_SET:   state_q <= S_SET;
							OP_BOX:   state_q <= S_BX_D;
							OP_PLANE: state_q <= S_SOP_MUL;
							default:  state_q <= S_FIN;
						endcase
					end
				end
				S_SET: begin
					for (int i = 0; i < 3; i++)
						pos_q[i] <= pt_q[i];
					state_q <= S_FIN;
				end
				S_MV_MUL: state_q <= S_MV_ADD;
				S_MV_ADD: begin
					pos_q[idx_q] <= sat32(52'(pos_q[idx_q]) + 52'(rnd16(prod_q)));
					if (idx_q == LAST_AXIS) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_MV_MUL;
					end
				end
				S_BX_D: begin
					state_q <= (|bx_far) ? S_FIN : S_SOP_MUL;
				end
				S_SOP_MUL: state_q <= S_SOP_ADD;
				S_SOP_ADD: begin
					if (idx_q == LAST_AXIS) begin
						idx_q <= '0;
						case (sel_q)
							SEL_SQ:  state_q <= S_SQ_INIT;
							SEL_PS:  state_q <= S_PS_CHK;
							SEL_DOT: state_q <= S_RF_DOT;
							default: state_q <= S_FIN;
						endcase
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_SOP_MUL;
					end
				end
				S_SQ_INIT: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST_STEP)
						state_q <= S_LEN;
				end
				S_LEN: begin
					idx_q   <= '0;
					sel_q   <= SEL_N;
					state_q <= len_miss ? S_FIN : S_DIV_INIT;
				end
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV_STEP;
				end
				S_DIV_STEP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST_STEP)
						state_q <= S_DIV_END;
				end
				S_DIV_END: begin
					if (sel_q == SEL_N && op_q == OP_BOX) begin
						state_q <= S_OFF_MUL;
					end else begin
						if (sel_q == SEL_OFF)
							pos_q[idx_q] <= sat32(52'(pos_q[idx_q]) - 52'(quo_s));
						if (idx_q == LAST_AXIS) begin
							idx_q   <= '0;
							sel_q   <= (op_q == OP_BOX) ? SEL_DOT : SEL_PS;
							state_q <= S_SOP_MUL;
						end else begin
							idx_q   <= idx_q + 2'd1;
							sel_q   <= SEL_N;
							state_q <= S_DIV_INIT;
						end
					end
				end
				S_OFF_MUL: begin
					sel_q   <= SEL_OFF;
					state_q <= S_DIV_INIT;
				end
				S_PS_CHK: begin
					idx_q   <= '0;
					state_q <= plane_miss ? S_FIN : S_PK_MUL;
				end
				S_PK_MUL: state_q <= S_PK_ADD;
				S_PK_ADD: begin
					pos_q[idx_q] <= sat32(52'(pos_q[idx_q]) + 52'(rnd16(prod_q)));
					if (idx_q == LAST_AXIS) begin
						idx_q   <= '0;
						sel_q   <= SEL_DOT;
						state_q <= S_SOP_MUL;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_PK_MUL;
					end
				end
				S_RF_DOT: begin
					idx_q   <= '0;
					state_q <= S_RF_MUL;
				end
				S_RF_MUL: state_q <= S_RF_ADD;
				S_RF_ADD: begin
					vel_q[idx_q] <= sat32(52'(vel_q[idx_q]) - 52'(rnd16(prod_q)));
					if (idx_q == LAST_AXIS) begin
						hit_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_RF_MUL;
					end
				end
				S_FIN: begin
					// Hold until the output register is free
					if (!out_valid_q || result_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p[65:0];

		// Accumulator clears outside a sum and holds for its consumer
		case (state_q)
			S_SOP_MUL, S_SQ_INIT, S_PS_CHK, S_RF_DOT: acc_q <= acc_q;
			S_SOP_ADD: acc_q <= acc_q + prod_q;
			default:   acc_q <= '0;
		endcase

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= item.opcode;
					pt_q[0]  <= item.point_x;
					pt_q[1]  <= item.point_y;
					pt_q[2]  <= item.point_z;
					ext_q[0] <= item.box_width;
					ext_q[1] <= item.box_height;
					ext_q[2] <= item.box_depth;
					dt_q     <= item.time_step;
					vec_q[0] <= 33'(item.normal_x);
					vec_q[1] <= 33'(item.normal_y);
					vec_q[2] <= 33'(item.normal_z);
				end
			end
			S_BX_D: begin
				for (int i = 0; i < 3; i++)
					vec_q[i] <= bx_d[i][32:0];
			end
			S_SQ_INIT: begin
				sqv_q <= acc_q[63:0];
				sqr_q <= '0;
				sqb_q <= 64'h4000_0000_0000_0000;
			end
			S_SQRT: begin
				if (sq_ge) begin
					sqv_q <= sqv_q - sq_t;
					sqr_q <= (sqr_q >> 1) + sqb_q;
				end else begin
					sqr_q <= sqr_q >> 1;
				end
				sqb_q <= sqb_q >> 2;
			end
			S_LEN: begin
				k_q <= $signed({2'b00, radius_q}) - $signed({1'b0, len_w});
			end
			S_DIV_INIT: begin
				neg_q <= dvd[65];
				rem_q <= dvd_mag[63:32];
				quo_q <= dvd_mag[31:0];
			end
			S_DIV_STEP: begin
				rem_q <= div_ge ? div_sub[31:0] : div_r2[31:0];
				quo_q <= {quo_q[30:0], div_ge};
			end
			S_DIV_END: begin
				if (sel_q == SEL_N)
					n_q[idx_q] <= quo_s[17:0];
			end
			S_PS_CHK: begin
				k_q <= k_w[32:0];
			end
			S_RF_DOT: begin
				dot2_q <= 34'(dot_w) <<< 1;
			end
			S_FIN: begin
				if (!out_valid_q || result_ready) begin
					out_q.hit   <= hit_q;
					out_q.pos_x <= pos_q[0];
					out_q.pos_y <= pos_q[1];
					out_q.pos_z <= pos_q[2];
					out_q.vel_x <= vel_q[0];
					out_q.vel_y <= vel_q[1];
					out_q.vel_z <= vel_q[2];
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

endmodule

// ----- rtl/core/bcr_checker.sv -----
// Ball collision response: port-level checker and its bind.
// Depends on bcr_pkg and the top level ball_collision_response.
module bcr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_ready,
	input bcr_pkg::item_t                 item,
	input logic                           result_valid,
	input logic                           result_ready,
	input bcr_pkg::result_t               result,
	input logic                           cfg_we,
	input logic [bcr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [bcr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bcr_pkg::*;

	logic               prev_valid_q;
	logic               taken_q;
	logic [1:0]         last_op_q;
	logic signed [31:0] last_x_q;
	logic signed [31:0] last_y_q;
	logic signed [31:0] last_z_q;
	logic               new_res;
	logic               cfg_seen;

	// Track the last accepted transaction and result handovers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			taken_q      <= 1'b0;
			last_op_q    <= OP_MOVE;
		end else begin
			prev_valid_q <= result_valid;
			taken_q      <= result_valid && result_ready;
			if (item_valid && item_ready)
				last_op_q <= item.opcode;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			last_x_q <= item.point_x;
			last_y_q <= item.point_y;
			last_z_q <= item.point_z;
		end
	end

	assign new_res  = result_valid && (!prev_valid_q || taken_q);
	assign cfg_seen = cfg_we && (cfg_index <= REG_START_VEL_Z) && (|cfg_data || !cfg_data[0]);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The block goes busy after it takes a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready stayed high after acceptance");

	// Set position returns the given point and no hit
	a_set: assert property (@(posedge clk) disable iff (!arst_n)
		new_res && (last_op_q == OP_SET) && !cfg_seen |->
			!result.hit && result.pos_x == last_x_q &&
			result.pos_y == last_y_q && result.pos_z == last_z_q)
		else $error("set position result mismatch");

	// A move never reports a hit
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		new_res && (last_op_q == OP_MOVE) |-> !result.hit)
		else $error("move reported a hit");

endmodule

bind ball_collision_response bcr_checker u_bcr_checker (.*);

// ----- tb/sv/ball_collision_checker.sv -----
`timescale 1ns / 1ps
// Ball collision response checker: watches the item, result and register ports.
// Predicts each result from its own copy of the ball state and compares field by field.
// Depends on bcr_pkg.
module ball_collision_checker import bcr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_ready,
	input  item_t                  item,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  result_t                result,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending,
	output int                     checked,
	output int                     hits
);

	logic [30:0]        radius;
	logic signed [31:0] start_pos [3];
	logic signed [31:0] start_vel [3];
	logic signed [31:0] ball_pos [3];
	logic signed [31:0] ball_vel [3];
	result_t            due_results [$];

	initial begin
		fail_count = 0;
		checked = 0;
		hits = 0;
	end

	assign pending = due_results.size();

	function automatic logic signed [31:0] clip32(longint x);
		if (x > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return x[31:0];
	endfunction

	// Round to nearest on the drop of 16 fraction bits, halves upwards
	function automatic longint round16(longint x);
		return (x + 64'sd32768) >>> 16;
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Reflect the velocity about a Q16.16 unit normal
	function automatic void bounce(longint n [3]);
		longint dot;
		dot = 0;
		for (int i = 0; i < 3; i++)
			dot += n[i] * longint'(ball_vel[i]);
		dot = round16(dot);
		for (int i = 0; i < 3; i++)
			ball_vel[i] = clip32(longint'(ball_vel[i]) - round16(2 * dot * n[i]));
	endfunction

	function automatic logic box_contact(item_t it);
		longint c [3];
		longint ext [3];
		longint d [3];
		longint n [3];
		longint half, diff, cl, len, off, r;
		longint unsigned sum;
		c = '{longint'(it.point_x), longint'(it.point_y), longint'(it.point_z)};
		ext = '{longint'(it.box_width), longint'(it.box_height), longint'(it.box_depth)};
		r = longint'(radius);
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			half = ext[i] >>> 1;
			diff = longint'(ball_pos[i]) - c[i];
			cl = diff;
			if (cl > half)
				cl = half;
			if (cl < -half)
				cl = -half;
			d[i] = cl - diff;
			if (d[i] >= r || -d[i] >= r)
				return 1'b0;
		end
		for (int i = 0; i < 3; i++)
			sum += longint'(d[i] * d[i]);
		len = longint'(floor_root(sum));
		if (len == 0 || len >= r)
			return 1'b0;
		off = r - len;
		for (int i = 0; i < 3; i++) begin
			n[i] = (d[i] * 64'sd65536) / len;
			ball_pos[i] = clip32(longint'(ball_pos[i]) - (d[i] * off) / len);
		end
		bounce(n);
		return 1'b1;
	endfunction

	function automatic logic plane_contact(item_t it);
		longint p [3];
		longint nv [3];
		longint n [3];
		longint s, k, len, r;
		longint unsigned sum;
		p = '{longint'(it.point_x), longint'(it.point_y), longint'(it.point_z)};
		nv = '{longint'(it.normal_x), longint'(it.normal_y), longint'(it.normal_z)};
		r = longint'(radius);
		sum = 0;
		for (int i = 0; i < 3; i++)
			sum += longint'(nv[i] * nv[i]);
		len = longint'(floor_root(sum));
		if (len == 0)
			return 1'b0;
		s = 0;
		for (int i = 0; i < 3; i++)
			n[i] = (nv[i] * 64'sd65536) / len;
		for (int i = 0; i < 3; i++)
			s += (longint'(ball_pos[i]) - p[i]) * n[i];
		s = round16(s);
		if (s == 0 || s >= r || -s >= r)
			return 1'b0;
		k = (s > 0) ? r - s : -r - s;
		for (int i = 0; i < 3; i++)
			ball_pos[i] = clip32(longint'(ball_pos[i]) + round16(n[i] * k));
		bounce(n);
		return 1'b1;
	endfunction

	// Advance the ball state by one transaction and build the result
	function automatic result_t advance_ball(item_t it);
		result_t res;
		logic contact;
		contact = 1'b0;
		case (it.opcode)
			OP_MOVE: begin
				for (int i = 0; i < 3; i++)
					ball_pos[i] = clip32(longint'(ball_pos[i]) +
						round16(longint'(ball_vel[i]) * longint'(it.time_step)));
			end
			OP_SET: begin
				ball_pos = '{it.point_x, it.point_y, it.point_z};
			end
			OP_BOX: contact = box_contact(it);
			default: contact = plane_contact(it);
		endcase
		res.hit = contact;
		res.pos_x = ball_pos[0];
		res.pos_y = ball_pos[1];
		res.pos_z = ball_pos[2];
		res.vel_x = ball_vel[0];
		res.vel_y = ball_vel[1];
		res.vel_z = ball_vel[2];
		return res;
	endfunction

	task automatic report(string field, longint want, longint got);
		$display("%0t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
		fail_count++;
	endtask

	// Track register writes, predict accepted items and check results
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			radius = RADIUS_RESET;
			for (int i = 0; i < 3; i++) begin
				start_pos[i] = '0;
				start_vel[i] = '0;
				ball_pos[i] = '0;
				ball_vel[i] = '0;
			end
			due_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_BALL_RADIUS)
					radius = cfg_data[30:0];
				else if (cfg_index < REG_START_POS_X + 3)
					start_pos[cfg_index - REG_START_POS_X] = cfg_data;
				else if (cfg_index <= REG_START_VEL_Z)
					start_vel[cfg_index - REG_START_POS_X - 3] = cfg_data;
			end
			if (result_valid && result_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t result with nothing expected", $time);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					checked++;
					if (want.hit)
						hits++;
					if (result.hit !== want.hit)
						report("hit", want.hit, result.hit);
					if (result.pos_x !== want.pos_x)
						report("pos_x", want.pos_x, result.pos_x);
					if (result.pos_y !== want.pos_y)
						report("pos_y", want.pos_y, result.pos_y);
					if (result.pos_z !== want.pos_z)
						report("pos_z", want.pos_z, result.pos_z);
					if (result.vel_x !== want.vel_x)
						report("vel_x", want.vel_x, result.vel_x);
					if (result.vel_y !== want.vel_y)
						report("vel_y", want.vel_y, result.vel_y);
					if (result.vel_z !== want.vel_z)
						report("vel_z", want.vel_z, result.vel_z);
				end
			end
			if (item_valid && item_ready)
				due_results.push_back(advance_ball(item));
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Ball collision response testbench top: clock, reset, stimulus and verdict.
// Depends on bcr_pkg, ball_collision_response and ball_collision_checker.
module tb;
	import bcr_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	item_t                 item;
	logic                  result_valid;
	logic                  result_ready;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;
	int                    checked;
	int                    hits;

	logic [30:0]           cur_radius;
	logic signed [31:0]    anchor [3];
	bit                    steady;
	int                    sent;

	ball_collision_response u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ball_collision_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .checked(checked), .hits(hits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("timeout");
		$display("tb NOT OK");
		$finish;
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 13);
	endfunction

	// Receiver: stall a random number of cycles before each result
	initial begin
		int gap;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	// Offer one transaction after a random gap and hold it until accepted
	task automatic send(item_t it);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		sent++;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [31:0] value);
		cfg_index <= idx[CFG_IDX_W-1:0];
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic item_t noise_item();
		logic [319:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
		longint v;
		v = longint'(base) + longint'($urandom_range(0, 2 * span)) - span;
		return v[31:0];
	endfunction

	// Build a random transaction, mostly aimed at the ball to provoke contacts
	function automatic item_t random_item();
		item_t it;
		int span;
		int pick;
		it = noise_item();
		pick = $urandom_range(0, 99);
		span = (cur_radius > 31'd500000) ? 1000000 : int'(cur_radius) * 2 + 16;
		if (pick < 10)
			return it;
		if (pick < 25) begin
			it.opcode = OP_SET;
			if ($urandom_range(0, 3) == 0) begin
				anchor = '{$urandom, $urandom, $urandom};
			end else begin
				for (int i = 0; i < 3; i++)
					anchor[i] = $urandom_range(0, 2000000) - 1000000;
			end
			{it.point_x, it.point_y, it.point_z} = {anchor[0], anchor[1], anchor[2]};
		end else if (pick < 35) begin
			it.opcode = OP_MOVE;
		end else if (pick < 70) begin
			it.opcode = OP_BOX;
			it.point_x = near(anchor[0], span);
			it.point_y = near(anchor[1], span);
			it.point_z = near(anchor[2], span);
			if ($urandom_range(0, 3) != 0) begin
				it.box_width = 31'($urandom_range(0, span));
				it.box_height = 31'($urandom_range(0, span));
				it.box_depth = 31'($urandom_range(0, span));
			end
		end else begin
			it.opcode = OP_PLANE;
			it.point_x = near(anchor[0], span);
			it.point_y = near(anchor[1], span);
			it.point_z = near(anchor[2], span);
			case ($urandom_range(0, 4))
				0: {it.normal_x, it.normal_y, it.normal_z} = '0;
				1: ;
				default: begin
					it.normal_x = $urandom_range(0, 262144) - 131072;
					it.normal_y = $urandom_range(0, 262144) - 131072;
					it.normal_z = $urandom_range(0, 262144) - 131072;
				end
			endcase
		end
		return it;
	endfunction

	function automatic item_t make_item(logic [1:0] op, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz, logic [30:0] ext,
			logic signed [31:0] nx, logic signed [31:0] ny, logic signed [31:0] nz,
			logic [20:0] dt);
		item_t it;
		it.opcode = op;
		{it.point_x, it.point_y, it.point_z} = {px, py, pz};
		{it.box_width, it.box_height, it.box_depth} = {ext, ext, ext};
		{it.normal_x, it.normal_y, it.normal_z} = {nx, ny, nz};
		it.time_step = dt;
		return it;
	endfunction

	// Directed cases around the origin and at the range extremes, with a unit radius
	task automatic directed();
		logic signed [31:0] smax;
		logic signed [31:0] smin;
		smax = 32'sh7FFFFFFF;
		smin = 32'sh80000000;
		send(make_item(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 21'h1FFFFF));
		send(make_item(OP_SET, smax, smin, smax, 31'h7FFFFFFF, smax, smin, smax, 0));
		send(make_item(OP_MOVE, smin, smax, smin, 0, 0, 0, 0, 21'd65536));
		send(make_item(OP_SET, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_item(OP_BOX, 80000, 0, 0, 65536, 0, 0, 0, 0));
		send(make_item(OP_BOX, 200000, 0, 0, 65536, 0, 0, 0, 0));
		send(make_item(OP_BOX, 0, 0, 0, 131072, 0, 0, 0, 0));
		send(make_item(OP_BOX, smin, smax, smin, 31'h7FFFFFFF, 0, 0, 0, 0));
		send(make_item(OP_BOX, 50000, 50000, 50000, 20000, 0, 0, 0, 0));
		send(make_item(OP_SET, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_item(OP_PLANE, 0, -30000, 0, 0, 0, 65536, 0, 0));
		send(make_item(OP_PLANE, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_item(OP_PLANE, 5, 7, 9, 0, 5, 7, 9, 0));
		send(make_item(OP_PLANE, 0, 20000, 0, 0, 0, -3, 0, 0));
		send(make_item(OP_PLANE, 0, 0, 0, 0, smax, smin, smax, 0));
		send(make_item(OP_PLANE, smax, smax, smax, 0, smin, smin, smin, 0));
		send(make_item(OP_PLANE, 10000, 10000, 10000, 0, 40000, -40000, 40000, 0));
		send(make_item(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 21'h100000));
	endtask

	initial begin
		logic [30:0] radii [6];
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_radius = RADIUS_RESET;
		anchor = '{0, 0, 0};
		steady = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		drain();

		radii = '{31'd65536, 31'd0, 31'h7FFFFFFF, 31'd1, 31'd262144, 31'd0};
		radii[5] = $urandom_range(1, 600000);
		for (int ph = 0; ph < 6; ph++) begin
			// Idle here: rewrite the radius, and the start-state registers once
			if (ph == 0) begin
				for (int r = REG_START_POS_X; r <= REG_START_VEL_Z; r++)
					write_reg(r, $urandom);
			end
			write_reg(REG_BALL_RADIUS, {1'b0, radii[ph]});
			cfg_we <= 1'b0;
			cur_radius = radii[ph];
			@(posedge clk);
			for (int n = 0; n < 335; n++) begin
				steady = ((n / 60) % 3) == 2;
				send(random_item());
			end
			drain();
		end

		$display("%0d transactions sent, %0d results checked, %0d contacts resolved",
			sent, checked, hits);
		$display("radius swept from zero to full scale over six settings");
		if (fail_count == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
